// File: src/json_string_unescape_utf8_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the JSON string unescaper.
// Each macro expands to one labelled concurrent assertion clocked on i_clk.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPE_UTF8_TOP_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_TOP_MACROS_SVH

// The condition must never hold outside reset.
`define JSU_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define JSU_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define JSU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/jsu_pkg.sv
// ----------------------------------------------------------------------------
// JSON string unescaper package
// Shared constants, result codes, the decoded group type and helper functions.
// ----------------------------------------------------------------------------
package jsu_pkg;

    localparam int CAP_W       = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [CAP_W-1:0] t_cap;
    typedef logic [CAP_W:0]   t_cap_ext;

    localparam t_cap CAP_RESET = t_cap'(256);

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    localparam logic [3:0] ERR_NONE      = 4'd0;
    localparam logic [3:0] ERR_NO_QUOTE  = 4'd1;
    localparam logic [3:0] ERR_BAD_ESC   = 4'd2;
    localparam logic [3:0] ERR_BAD_HEX   = 4'd3;
    localparam logic [3:0] ERR_NO_LOW    = 4'd4;
    localparam logic [3:0] ERR_LOW_RANGE = 4'd5;
    localparam logic [3:0] ERR_LONE_LOW  = 4'd6;
    localparam logic [3:0] ERR_CONTROL   = 4'd7;
    localparam logic [3:0] ERR_FULL      = 4'd8;
    localparam logic [3:0] ERR_UNTERM    = 4'd9;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [15:0] HIGH_FIRST = 16'hD800;
    localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
    localparam logic [15:0] LOW_FIRST  = 16'hDC00;
    localparam logic [15:0] LOW_LAST   = 16'hDFFF;
    localparam logic [20:0] PLANE_BASE = 21'h10000;

    // All results caused by one input byte: an optional leading abandon error,
    // up to four data bytes, then an optional completion or error.
    typedef struct packed {
        logic            pre9;
        logic [2:0]      nb;
        logic [3:0][7:0] bytes;
        logic            tail;
        logic [1:0]      tkind;
        logic [3:0]      tcode;
    } t_group;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic [2:0]      len;
        logic [3:0][7:0] bytes;
    } t_utf8;

    function automatic logic [4:0] nibble_decode(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        priority if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, b[3:0]};
        end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            r = {1'b1, 4'(b[3:0] + 4'd9)};
        end else begin
            r = 5'd0;
        end
        return r;
    endfunction

    function automatic t_utf8 utf8_encode(input logic [20:0] cp);
        t_utf8 r;
        r = '0;
        priority if (cp <= 21'h7F) begin
            r.len      = 3'd1;
            r.bytes[0] = cp[7:0];
        end else if (cp <= 21'h7FF) begin
            r.len      = 3'd2;
            r.bytes[0] = {3'b110, cp[10:6]};
            r.bytes[1] = {2'b10, cp[5:0]};
        end else if (cp <= 21'hFFFF) begin
            r.len      = 3'd3;
            r.bytes[0] = {4'b1110, cp[15:12]};
            r.bytes[1] = {2'b10, cp[11:6]};
            r.bytes[2] = {2'b10, cp[5:0]};
        end else begin
            r.len      = 3'd4;
            r.bytes[0] = {5'b11110, cp[20:18]};
            r.bytes[1] = {2'b10, cp[17:12]};
            r.bytes[2] = {2'b10, cp[11:6]};
            r.bytes[3] = {2'b10, cp[5:0]};
        end
        return r;
    endfunction

endpackage

// File: src/json_string_unescape_utf8_top.sv
// ----------------------------------------------------------------------------
// JSON string unescaper to UTF-8
// Top level: front decoder, group queue and result back end.
// ----------------------------------------------------------------------------
// The input channel takes one byte of a quoted JSON string span per word,
// with i_span_start on the opening quote and i_span_last on the final byte.
// The output channel gives one result per word: a decoded data byte, a
// completion, or an error with its code; o_run_last marks the last result
// caused by an input byte. Bytes that produce no result give no word.
// The configuration channel writes the output capacity; o_cfg_ready is
// always high. The user must make writes only while the block is idle;
// the block does not enforce it. An input byte is decoded in the cycle
// it is accepted, one byte per cycle while the queue is not full.
// Its results reach the output through the group queue, the working group
// and the output register. A byte that expands into several results (up
// to five) gives one per word, while a four-group queue accepts input.
// The receiver may stall at any time: the output word holds, the queue
// fills, and o_in_stall rises when the queue is full. Reset clears the
// decoder to idle, empties the queue and restores the capacity to 256.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_span_start,
    input  logic                  i_span_last,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [7:0]            o_out_byte,
    output logic [1:0]            o_kind,
    output logic [3:0]            o_error_code,
    output logic                  o_run_last,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [15:0]           i_cfg_data
);

    logic                  accept;
    logic                  push;
    logic                  pop;
    jsu_pkg::t_group       group;
    jsu_pkg::t_group       head;
    jsu_pkg::t_q_status    status;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = status.full;
    assign accept      = i_in_valid && !status.full;

    jsu_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_data_byte  (i_data_byte),
        .i_span_start (i_span_start),
        .i_span_last  (i_span_last),
        .i_cfg_write  (i_cfg_valid && o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_push       (push),
        .o_group      (group)
    );

    jsu_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_group  (group),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (status)
    );

    jsu_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_status     (status),
        .o_pop        (pop),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_out_byte   (o_out_byte),
        .o_kind       (o_kind),
        .o_error_code (o_error_code),
        .o_run_last   (o_run_last)
    );

endmodule

// File: src/jsu_front.sv
// ----------------------------------------------------------------------------
// JSON string unescaper front end
// Decodes one accepted input byte per cycle into a group of pending results.
// ----------------------------------------------------------------------------
module jsu_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_span_start,
    input  logic                  i_span_last,
    input  logic                  i_cfg_write,
    input  jsu_pkg::t_cap         i_cfg_data,
    output logic                  o_push,
    output jsu_pkg::t_group       o_group
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_BODY,
        PH_ESC,
        PH_HEX1,
        PH_WANT_BS,
        PH_WANT_U,
        PH_HEX2
    } t_phase;

    t_phase          r_phase, n_phase;
    jsu_pkg::t_cap   r_cap;
    jsu_pkg::t_cap   r_used, n_used;
    logic [15:0]     r_acc, n_acc;
    logic [1:0]      r_cnt, n_cnt;
    logic [9:0]      r_high, n_high;

    jsu_pkg::t_group grp;
    logic [4:0]      hex;
    logic [15:0]     new_acc;
    logic [20:0]     cp;
    jsu_pkg::t_utf8  enc;
    logic            cp_fits;
    logic            one_fits;
    logic [7:0]      esc_val;
    logic            esc_ok;

    always_comb begin
        hex      = jsu_pkg::nibble_decode(i_data_byte);
        new_acc  = {r_acc[11:0], hex[3:0]};
        cp       = (r_phase == PH_HEX2) ?
                   jsu_pkg::PLANE_BASE + {1'b0, r_high, new_acc[9:0]} : {5'd0, new_acc};
        enc      = jsu_pkg::utf8_encode(cp);
        cp_fits  = ({1'b0, r_used} + jsu_pkg::t_cap_ext'(enc.len)) < {1'b0, r_cap};
        one_fits = ({1'b0, r_used} + jsu_pkg::t_cap_ext'(1)) < {1'b0, r_cap};

        esc_ok  = 1'b1;
        esc_val = 8'h00;
        unique case (i_data_byte)
            jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSL, jsu_pkg::CH_SLASH: esc_val = i_data_byte;
            jsu_pkg::CH_B: esc_val = 8'h08;
            jsu_pkg::CH_F: esc_val = 8'h0C;
            jsu_pkg::CH_N: esc_val = 8'h0A;
            jsu_pkg::CH_R: esc_val = 8'h0D;
            jsu_pkg::CH_T: esc_val = 8'h09;
            default: esc_ok = 1'b0;
        endcase

        grp     = '0;
        n_phase = r_phase;
        n_used  = r_used;
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_high  = r_high;

        if (i_span_start) begin
            grp.pre9 = (r_phase != PH_IDLE);
            n_used   = '0;
            n_acc    = '0;
            n_cnt    = '0;
            n_high   = '0;
            if (i_data_byte != jsu_pkg::CH_QUOTE) begin
                grp.tail  = 1'b1;
                grp.tkind = jsu_pkg::KIND_ERR;
                grp.tcode = jsu_pkg::ERR_NO_QUOTE;
                n_phase   = PH_IDLE;
            end else begin
                n_phase = PH_BODY;
            end
        end else begin
            unique case (r_phase)
                PH_BODY: begin
                    priority if (i_data_byte == jsu_pkg::CH_QUOTE) begin
                        grp.tail  = 1'b1;
                        grp.tkind = (r_used >= r_cap) ? jsu_pkg::KIND_ERR : jsu_pkg::KIND_DONE;
                        grp.tcode = (r_used >= r_cap) ? jsu_pkg::ERR_FULL : jsu_pkg::ERR_NONE;
                        n_phase   = PH_IDLE;
                    end else if (i_data_byte == jsu_pkg::CH_BSL) begin
                        n_phase = PH_ESC;
                    end else if (!one_fits) begin
                        grp.tail  = 1'b1;
                        grp.tkind = jsu_pkg::KIND_ERR;
                        grp.tcode = jsu_pkg::ERR_FULL;
                        n_phase   = PH_IDLE;
                    end else if (i_data_byte < jsu_pkg::CH_SPACE) begin
                        grp.tail  = 1'b1;
                        grp.tkind = jsu_pkg::KIND_ERR;
                        grp.tcode = jsu_pkg::ERR_CONTROL;
                        n_phase   = PH_IDLE;
                    end else begin
                        grp.nb       = 3'd1;
                        grp.bytes[0] = i_data_byte;
                        n_used       = r_used + jsu_pkg::t_cap'(1);
                    end
                end
                PH_ESC: begin
                    priority if (esc_ok) begin
                        if (!one_fits) begin
                            grp.tail  = 1'b1;
                            grp.tkind = jsu_pkg::KIND_ERR;
                            grp.tcode = jsu_pkg::ERR_FULL;
                            n_phase   = PH_IDLE;
                        end else begin
                            grp.nb       = 3'd1;
                            grp.bytes[0] = esc_val;
                            n_used       = r_used + jsu_pkg::t_cap'(1);
                            n_phase      = PH_BODY;
                        end
                    end else if (i_data_byte == jsu_pkg::CH_U) begin
                        n_phase = PH_HEX1;
                        n_acc   = '0;
                        n_cnt   = '0;
                    end else begin
                        grp.tail  = 1'b1;
                        grp.tkind = jsu_pkg::KIND_ERR;
                        grp.tcode = jsu_pkg::ERR_BAD_ESC;
                        n_phase   = PH_IDLE;
                    end
                end
                PH_HEX1, PH_HEX2: begin
                    priority if (!hex[4]) begin
                        grp.tail  = 1'b1;
                        grp.tkind = jsu_pkg::KIND_ERR;
                        grp.tcode = jsu_pkg::ERR_BAD_HEX;
                        n_phase   = PH_IDLE;
                    end else if (r_cnt != 2'd3) begin
                        n_acc = new_acc;
                        n_cnt = r_cnt + 2'd1;
                    end else begin
                        n_acc = new_acc;
                        n_cnt = '0;
                        priority if (r_phase == PH_HEX1 && new_acc >= jsu_pkg::HIGH_FIRST
                                     && new_acc <= jsu_pkg::HIGH_LAST) begin
                            n_high  = new_acc[9:0];
                            n_phase = PH_WANT_BS;
                        end else if (r_phase == PH_HEX1 && new_acc >= jsu_pkg::LOW_FIRST
                                     && new_acc <= jsu_pkg::LOW_LAST) begin
                            grp.tail  = 1'b1;
                            grp.tkind = jsu_pkg::KIND_ERR;
                            grp.tcode = jsu_pkg::ERR_LONE_LOW;
                            n_phase   = PH_IDLE;
                        end else if (r_phase == PH_HEX2 && (new_acc < jsu_pkg::LOW_FIRST
                                     || new_acc > jsu_pkg::LOW_LAST)) begin
                            grp.tail  = 1'b1;
                            grp.tkind = jsu_pkg::KIND_ERR;
                            grp.tcode = jsu_pkg::ERR_LOW_RANGE;
                            n_phase   = PH_IDLE;
                        end else if (!cp_fits) begin
                            grp.tail  = 1'b1;
                            grp.tkind = jsu_pkg::KIND_ERR;
                            grp.tcode = jsu_pkg::ERR_FULL;
                            n_phase   = PH_IDLE;
                        end else begin
                            grp.nb    = enc.len;
                            grp.bytes = enc.bytes;
                            n_used    = r_used + jsu_pkg::t_cap'(enc.len);
                            n_phase   = PH_BODY;
                        end
                    end
                end
                PH_WANT_BS: begin
                    if (i_data_byte == jsu_pkg::CH_BSL) begin
                        n_phase = PH_WANT_U;
                    end else begin
                        grp.tail  = 1'b1;
                        grp.tkind = jsu_pkg::KIND_ERR;
                        grp.tcode = jsu_pkg::ERR_NO_LOW;
                        n_phase   = PH_IDLE;
                    end
                end
                PH_WANT_U: begin
                    if (i_data_byte == jsu_pkg::CH_U) begin
                        n_phase = PH_HEX2;
                        n_acc   = '0;
                        n_cnt   = '0;
                    end else begin
                        grp.tail  = 1'b1;
                        grp.tkind = jsu_pkg::KIND_ERR;
                        grp.tcode = jsu_pkg::ERR_NO_LOW;
                        n_phase   = PH_IDLE;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end

        // A span that ends while the string is still open is unterminated.
        if (i_span_last && n_phase != PH_IDLE) begin
            grp.tail  = 1'b1;
            grp.tkind = jsu_pkg::KIND_ERR;
            grp.tcode = jsu_pkg::ERR_UNTERM;
            n_phase   = PH_IDLE;
        end
    end

    assign o_group = grp;
    assign o_push  = i_accept && (grp.pre9 || grp.nb != 3'd0 || grp.tail);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cap   <= jsu_pkg::CAP_RESET;
            r_used  <= '0;
            r_acc   <= '0;
            r_cnt   <= '0;
            r_high  <= '0;
        end else begin
            if (i_cfg_write) begin
                r_cap <= i_cfg_data;
            end
            if (i_accept) begin
                r_phase <= n_phase;
                r_used  <= n_used;
                r_acc   <= n_acc;
                r_cnt   <= n_cnt;
                r_high  <= n_high;
            end
        end
    end

endmodule

// File: src/jsu_queue.sv
// ----------------------------------------------------------------------------
// JSON string unescaper group queue
// A short first-in first-out queue of decoded groups between front and back.
// ----------------------------------------------------------------------------
module jsu_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  jsu_pkg::t_group       i_group,
    input  logic                  i_pop,
    output jsu_pkg::t_group       o_head,
    output jsu_pkg::t_q_status    o_status
);

    jsu_pkg::t_group                 r_mem [jsu_pkg::QUEUE_DEPTH];
    logic [jsu_pkg::QPTR_W-1:0]      r_wr;
    logic [jsu_pkg::QPTR_W-1:0]      r_rd;
    logic [jsu_pkg::QCNT_W-1:0]      r_count;

    assign o_head         = r_mem[r_rd];
    assign o_status.full  = (r_count == jsu_pkg::QCNT_W'(jsu_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_group;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + jsu_pkg::QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + jsu_pkg::QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + jsu_pkg::QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - jsu_pkg::QCNT_W'(1);
            end
        end
    end

`include "json_string_unescape_utf8_top_macros.svh"

    `JSU_ASSERT_NEVER(a_no_overflow, i_push && !i_pop && o_status.full, "queue overflow")
    `JSU_ASSERT_NEVER(a_no_underflow, i_pop && o_status.empty, "queue underflow")

endmodule

// File: src/jsu_back.sv
// ----------------------------------------------------------------------------
// JSON string unescaper back end
// Unpacks queued groups into single results behind a registered output.
// ----------------------------------------------------------------------------
module jsu_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  jsu_pkg::t_group       i_head,
    input  jsu_pkg::t_q_status    i_status,
    output logic                  o_pop,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output logic [7:0]            o_out_byte,
    output logic [1:0]            o_kind,
    output logic [3:0]            o_error_code,
    output logic                  o_run_last
);

    jsu_pkg::t_group r_w, n_w;
    logic            r_wvalid;
    logic            r_out_valid;
    logic [7:0]      r_out_byte;
    logic [1:0]      r_kind;
    logic [3:0]      r_code;
    logic            r_last;

    logic            take;
    logic            emit;
    logic            rem;
    logic [7:0]      cur_byte;
    logic [1:0]      cur_kind;
    logic [3:0]      cur_code;

    always_comb begin
        take     = !r_out_valid || !i_out_stall;
        emit     = take && r_wvalid;
        n_w      = r_w;
        cur_byte = 8'h00;
        cur_kind = jsu_pkg::KIND_ERR;
        cur_code = jsu_pkg::ERR_UNTERM;
        priority if (r_w.pre9) begin
            n_w.pre9 = 1'b0;
            rem      = (r_w.nb != 3'd0) || r_w.tail;
        end else if (r_w.nb != 3'd0) begin
            cur_byte  = r_w.bytes[0];
            cur_kind  = jsu_pkg::KIND_DATA;
            cur_code  = jsu_pkg::ERR_NONE;
            n_w.bytes = {8'h00, r_w.bytes[3:1]};
            n_w.nb    = r_w.nb - 3'd1;
            rem       = (r_w.nb != 3'd1) || r_w.tail;
        end else begin
            cur_kind = r_w.tkind;
            cur_code = r_w.tcode;
            n_w.tail = 1'b0;
            rem      = 1'b0;
        end
        o_pop = !i_status.empty && (!r_wvalid || (emit && !rem));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wvalid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_wvalid <= 1'b1;
            end else if (emit) begin
                r_wvalid <= rem;
            end
            if (take) begin
                r_out_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_w <= i_head;
        end else if (emit) begin
            r_w <= n_w;
        end
        if (emit) begin
            r_out_byte <= cur_byte;
            r_kind     <= cur_kind;
            r_code     <= cur_code;
            r_last     <= !rem;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_kind       = r_kind;
    assign o_error_code = r_code;
    assign o_run_last   = r_last;

`include "json_string_unescape_utf8_top_macros.svh"

    `JSU_ASSERT_IMPL(a_work_nonempty, r_wvalid, r_w.pre9 || r_w.nb != 3'd0 || r_w.tail,
        "working group holds no result")
    `JSU_ASSERT_IMPL(a_burst_len, r_wvalid, r_w.nb <= 3'd4, "data burst longer than four")
    `JSU_ASSERT_NEXT(a_data_code, emit && cur_kind == jsu_pkg::KIND_DATA,
        o_error_code == jsu_pkg::ERR_NONE && o_out_valid, "data result carries an error code")

endmodule

// File: verif/json_string_unescape_utf8_top_test.sv
// ----------------------------------------------------------------------------
// JSON string unescaper to UTF-8: self-checking testbench
// Feeds quoted string spans one byte per word, directed first and then random,
// well-formed spans with faults mixed in. Each accepted byte is run through a
// local model of the decoder. Every output word is compared with the oldest
// expected word, under random idling, stalling and a long receiver hold-off.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int SETTLE_CYCLES  = 12;
    localparam int FINAL_CYCLES   = 20;
    localparam int HOLDOFF_CYCLES = 150;
    localparam int REPORT_LINES   = 50;

    localparam logic [7:0][7:0] ESC_CHARS = {jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSL,
                                             jsu_pkg::CH_SLASH, jsu_pkg::CH_B,
                                             jsu_pkg::CH_F, jsu_pkg::CH_N,
                                             jsu_pkg::CH_R, jsu_pkg::CH_T};

    typedef enum logic [2:0] {
        ST_IDLE, ST_BODY, ST_ESCAPE, ST_HEX_HIGH, ST_NEED_BSL, ST_NEED_U, ST_HEX_LOW
    } t_dec_state;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic [3:0] code;
        logic       run_last;
    } t_word;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_data_byte  = 8'h00;
    logic        i_span_start = 1'b0;
    logic        i_span_last  = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall  = 1'b0;
    logic [7:0]  o_out_byte;
    logic [1:0]  o_kind;
    logic [3:0]  o_error_code;
    logic        o_run_last;
    logic        i_cfg_valid  = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data   = 16'h0000;

    t_word       expected_words[$];
    t_word       step_words[$];
    logic [7:0]  span_bytes[$];

    t_dec_state  dec_state    = ST_IDLE;
    logic [15:0] hex_acc      = '0;
    logic [1:0]  hex_cnt      = '0;
    logic [9:0]  high_bits    = '0;
    int unsigned bytes_out    = 0;
    int unsigned capacity     = 256;

    int          idle_pct     = 0;
    int          stall_pct    = 0;
    int          bytes_sent   = 0;
    int          mismatch_count = 0;
    int          cycle_count  = 0;
    int          holdoff_left = 0;
    logic        holdoff_req  = 1'b0;

    json_string_unescape_utf8_top u_top (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int hex_nibble(input logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39) return int'(b) - 'h30;
        if (b >= 8'h61 && b <= 8'h66) return int'(b) - 'h61 + 10;
        if (b >= 8'h41 && b <= 8'h46) return int'(b) - 'h41 + 10;
        return -1;
    endfunction

    function automatic void add_word(input logic [7:0] b, input logic [1:0] k,
                                     input logic [3:0] c);
        t_word w;
        w.out_byte = b;
        w.kind     = k;
        w.code     = c;
        w.run_last = 1'b0;
        step_words.push_back(w);
    endfunction

    function automatic void abort_span(input logic [3:0] c);
        add_word(8'h00, jsu_pkg::KIND_ERR, c);
        dec_state = ST_IDLE;
    endfunction

    function automatic void emit_code_point(input logic [20:0] cp);
        int unsigned len;
        len = (cp <= 21'h7F) ? 1 : (cp <= 21'h7FF) ? 2 : (cp <= 21'hFFFF) ? 3 : 4;
        if (bytes_out + len >= capacity) begin
            abort_span(jsu_pkg::ERR_FULL);
            return;
        end
        case (len)
            1: add_word(cp[7:0], jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
            2: begin
                add_word(8'hC0 | 8'(cp >> 6), jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
                add_word(8'h80 | 8'(cp & 21'h3F), jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
            end
            3: begin
                add_word(8'hE0 | 8'(cp >> 12), jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
                add_word(8'h80 | 8'((cp >> 6) & 21'h3F), jsu_pkg::KIND_DATA,
                         jsu_pkg::ERR_NONE);
                add_word(8'h80 | 8'(cp & 21'h3F), jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
            end
            default: begin
                add_word(8'hF0 | 8'(cp >> 18), jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
                add_word(8'h80 | 8'((cp >> 12) & 21'h3F), jsu_pkg::KIND_DATA,
                         jsu_pkg::ERR_NONE);
                add_word(8'h80 | 8'((cp >> 6) & 21'h3F), jsu_pkg::KIND_DATA,
                         jsu_pkg::ERR_NONE);
                add_word(8'h80 | 8'(cp & 21'h3F), jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
            end
        endcase
        bytes_out += len;
        dec_state = ST_BODY;
    endfunction

    function automatic void predict_unescape(input logic [7:0] b, input logic start,
                                             input logic last);
        logic [8:0] simple;
        int         nib;
        step_words.delete();
        if (start) begin
            if (dec_state != ST_IDLE) abort_span(jsu_pkg::ERR_UNTERM);
            bytes_out = 0;
            hex_acc   = '0;
            hex_cnt   = '0;
            high_bits = '0;
            if (b != jsu_pkg::CH_QUOTE) abort_span(jsu_pkg::ERR_NO_QUOTE);
            else dec_state = ST_BODY;
        end else begin
            case (dec_state)
                ST_BODY: begin
                    if (b == jsu_pkg::CH_QUOTE) begin
                        if (bytes_out >= capacity) begin
                            abort_span(jsu_pkg::ERR_FULL);
                        end else begin
                            add_word(8'h00, jsu_pkg::KIND_DONE, jsu_pkg::ERR_NONE);
                            dec_state = ST_IDLE;
                        end
                    end else if (b == jsu_pkg::CH_BSL) begin
                        dec_state = ST_ESCAPE;
                    end else if (bytes_out + 1 >= capacity) begin
                        abort_span(jsu_pkg::ERR_FULL);
                    end else if (b < jsu_pkg::CH_SPACE) begin
                        abort_span(jsu_pkg::ERR_CONTROL);
                    end else begin
                        add_word(b, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
                        bytes_out++;
                    end
                end
                ST_ESCAPE: begin
                    case (b)
                        jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSL, jsu_pkg::CH_SLASH:
                            simple = {1'b0, b};
                        jsu_pkg::CH_B: simple = 9'h008;
                        jsu_pkg::CH_F: simple = 9'h00C;
                        jsu_pkg::CH_N: simple = 9'h00A;
                        jsu_pkg::CH_R: simple = 9'h00D;
                        jsu_pkg::CH_T: simple = 9'h009;
                        default: simple = 9'h100;
                    endcase
                    if (!simple[8]) begin
                        if (bytes_out + 1 >= capacity) begin
                            abort_span(jsu_pkg::ERR_FULL);
                        end else begin
                            add_word(simple[7:0], jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
                            bytes_out++;
                            dec_state = ST_BODY;
                        end
                    end else if (b == jsu_pkg::CH_U) begin
                        dec_state = ST_HEX_HIGH;
                        hex_acc   = '0;
                        hex_cnt   = '0;
                    end else begin
                        abort_span(jsu_pkg::ERR_BAD_ESC);
                    end
                end
                ST_HEX_HIGH, ST_HEX_LOW: begin
                    nib = hex_nibble(b);
                    if (nib < 0) begin
                        abort_span(jsu_pkg::ERR_BAD_HEX);
                    end else begin
                        hex_acc = {hex_acc[11:0], nib[3:0]};
                        if (hex_cnt != 2'd3) begin
                            hex_cnt++;
                        end else begin
                            hex_cnt = '0;
                            if (dec_state == ST_HEX_HIGH) begin
                                if (hex_acc >= jsu_pkg::HIGH_FIRST &&
                                    hex_acc <= jsu_pkg::HIGH_LAST) begin
                                    high_bits = 10'(hex_acc - jsu_pkg::HIGH_FIRST);
                                    dec_state = ST_NEED_BSL;
                                end else if (hex_acc >= jsu_pkg::LOW_FIRST &&
                                             hex_acc <= jsu_pkg::LOW_LAST) begin
                                    abort_span(jsu_pkg::ERR_LONE_LOW);
                                end else begin
                                    emit_code_point({5'd0, hex_acc});
                                end
                            end else if (hex_acc < jsu_pkg::LOW_FIRST ||
                                         hex_acc > jsu_pkg::LOW_LAST) begin
                                abort_span(jsu_pkg::ERR_LOW_RANGE);
                            end else begin
                                emit_code_point(jsu_pkg::PLANE_BASE +
                                    {1'b0, high_bits, 10'(hex_acc - jsu_pkg::LOW_FIRST)});
                            end
                        end
                    end
                end
                ST_NEED_BSL: begin
                    if (b == jsu_pkg::CH_BSL) dec_state = ST_NEED_U;
                    else abort_span(jsu_pkg::ERR_NO_LOW);
                end
                ST_NEED_U: begin
                    if (b == jsu_pkg::CH_U) begin
                        dec_state = ST_HEX_LOW;
                        hex_acc   = '0;
                        hex_cnt   = '0;
                    end else begin
                        abort_span(jsu_pkg::ERR_NO_LOW);
                    end
                end
                default: dec_state = ST_IDLE;
            endcase
        end
        if (last && dec_state != ST_IDLE) abort_span(jsu_pkg::ERR_UNTERM);
        if (step_words.size() != 0) step_words[step_words.size() - 1].run_last = 1'b1;
        foreach (step_words[i]) expected_words.push_back(step_words[i]);
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_LINES) $display("mismatch at %0t ns: %s", $time, what);
    endtask

    always @(posedge i_clk) begin : check_results
        t_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word kind %0d code %0d byte %02h",
                                          o_kind, o_error_code, o_out_byte));
            end else begin
                want = expected_words.pop_front();
                if (o_out_byte !== want.out_byte)
                    report_mismatch($sformatf("byte %02h, expected %02h",
                                              o_out_byte, want.out_byte));
                if (o_kind !== want.kind)
                    report_mismatch($sformatf("kind %0d, expected %0d", o_kind, want.kind));
                if (o_error_code !== want.code)
                    report_mismatch($sformatf("error code %0d, expected %0d",
                                              o_error_code, want.code));
                if (o_run_last !== want.run_last)
                    report_mismatch($sformatf("run last %0b, expected %0b",
                                              o_run_last, want.run_last));
            end
        end
        i_out_stall <= (holdoff_left != 0) || ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (holdoff_left != 0) holdoff_left <= holdoff_left - 1;
        else if (holdoff_req) holdoff_left <= HOLDOFF_CYCLES;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic start, input logic last);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_data_byte  <= b;
        i_span_start <= start;
        i_span_last  <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_unescape(b, start, last);
        bytes_sent++;
    endtask

    task automatic send_span(input logic mark_last);
        for (int i = 0; i < span_bytes.size(); i++)
            send_byte(span_bytes[i], i == 0, mark_last && (i == span_bytes.size() - 1));
    endtask

    task automatic wait_drained(input int settle);
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic set_capacity(input logic [15:0] value);
        wait_drained(SETTLE_CYCLES);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        capacity = value;
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return 8'h30 + 8'(n);
        return (($urandom_range(1) != 0) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
    endfunction

    task automatic queue_u_escape(input logic [15:0] v);
        span_bytes.push_back(jsu_pkg::CH_BSL);
        span_bytes.push_back(jsu_pkg::CH_U);
        for (int i = 3; i >= 0; i--) span_bytes.push_back(hex_char(v[i*4 +: 4]));
    endtask

    task automatic queue_unit();
        logic [7:0]  b;
        logic [15:0] v;
        int          pick;
        pick = $urandom_range(9);
        if (pick < 5) begin
            do b = 8'($urandom_range(8'hFF, 8'h20));
            while (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BSL);
            span_bytes.push_back(b);
        end else if (pick < 7) begin
            span_bytes.push_back(jsu_pkg::CH_BSL);
            span_bytes.push_back(ESC_CHARS[$urandom_range(7)]);
        end else if (pick < 9) begin
            case ($urandom_range(2))
                0: v = 16'($urandom_range(16'h7F));
                1: v = 16'($urandom_range(16'h7FF, 16'h80));
                default: begin
                    do v = 16'($urandom_range(16'hFFFF, 16'h800));
                    while (v >= jsu_pkg::HIGH_FIRST && v <= jsu_pkg::LOW_LAST);
                end
            endcase
            queue_u_escape(v);
        end else begin
            queue_u_escape(16'($urandom_range(jsu_pkg::HIGH_LAST, jsu_pkg::HIGH_FIRST)));
            queue_u_escape(16'($urandom_range(jsu_pkg::LOW_LAST, jsu_pkg::LOW_FIRST)));
        end
    endtask

    task automatic make_span(output logic mark_last);
        logic [7:0]  b;
        logic [15:0] v;
        int          fault;
        mark_last = 1'b1;
        span_bytes.delete();
        span_bytes.push_back(jsu_pkg::CH_QUOTE);
        repeat (($urandom_range(19) == 0) ? $urandom_range(20, 10) : $urandom_range(4))
            queue_unit();
        fault = ($urandom_range(99) < 30) ? $urandom_range(9, 1) : 0;
        case (fault)
            1: span_bytes.push_back(8'($urandom_range(8'h1F)));
            2: begin
                do b = 8'($urandom);
                while (b inside {jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSL, jsu_pkg::CH_SLASH,
                                 jsu_pkg::CH_B, jsu_pkg::CH_F, jsu_pkg::CH_N,
                                 jsu_pkg::CH_R, jsu_pkg::CH_T, jsu_pkg::CH_U});
                span_bytes.push_back(jsu_pkg::CH_BSL);
                span_bytes.push_back(b);
            end
            3: begin
                span_bytes.push_back(jsu_pkg::CH_BSL);
                span_bytes.push_back(jsu_pkg::CH_U);
                repeat ($urandom_range(3)) span_bytes.push_back(hex_char(4'($urandom)));
                do b = 8'($urandom); while (hex_nibble(b) >= 0);
                span_bytes.push_back(b);
            end
            4: queue_u_escape(16'($urandom_range(jsu_pkg::LOW_LAST, jsu_pkg::LOW_FIRST)));
            5: begin
                queue_u_escape(16'($urandom_range(jsu_pkg::HIGH_LAST, jsu_pkg::HIGH_FIRST)));
                if ($urandom_range(1) != 0) begin
                    do b = 8'($urandom); while (b == jsu_pkg::CH_BSL);
                    span_bytes.push_back(b);
                end else begin
                    span_bytes.push_back(jsu_pkg::CH_BSL);
                    do b = 8'($urandom); while (b == jsu_pkg::CH_U);
                    span_bytes.push_back(b);
                end
            end
            6: begin
                queue_u_escape(16'($urandom_range(jsu_pkg::HIGH_LAST, jsu_pkg::HIGH_FIRST)));
                do v = 16'($urandom);
                while (v >= jsu_pkg::LOW_FIRST && v <= jsu_pkg::LOW_LAST);
                queue_u_escape(v);
            end
            7: begin
                do b = 8'($urandom); while (b == jsu_pkg::CH_QUOTE);
                span_bytes[0] = b;
            end
            8: repeat ($urandom_range(span_bytes.size() - 1)) void'(span_bytes.pop_back());
            9: mark_last = 1'b0;
            default: ;
        endcase
        if (fault != 8 && fault != 9) begin
            if (fault != 0 && $urandom_range(1) != 0) queue_unit();
            span_bytes.push_back(jsu_pkg::CH_QUOTE);
            if ($urandom_range(4) == 0) span_bytes.push_back(8'($urandom));
        end
    endtask

    task automatic test_directed();
        idle_pct  = 0;
        stall_pct = 0;
        span_bytes = '{jsu_pkg::CH_QUOTE, 8'hFF, jsu_pkg::CH_BSL, jsu_pkg::CH_N,
                       jsu_pkg::CH_QUOTE};
        send_span(1'b1);
        span_bytes = '{jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSL, jsu_pkg::CH_U,
                       8'h30, 8'h30, 8'h30, 8'h30};
        send_span(1'b1);
        span_bytes = '{jsu_pkg::CH_QUOTE, 8'h41};
        send_span(1'b0);
        span_bytes = '{jsu_pkg::CH_QUOTE, jsu_pkg::CH_QUOTE, 8'h7A};
        send_span(1'b1);
        span_bytes = '{8'h78, 8'h79};
        send_span(1'b1);
        span_bytes = '{jsu_pkg::CH_QUOTE, 8'h00};
        send_span(1'b1);
        span_bytes = '{jsu_pkg::CH_QUOTE};
        send_span(1'b1);
    endtask

    task automatic test_capacity_limits();
        idle_pct  = 26;
        stall_pct = 26;
        set_capacity(16'd1);
        span_bytes = '{jsu_pkg::CH_QUOTE, 8'h01};
        send_span(1'b1);
        span_bytes = '{jsu_pkg::CH_QUOTE, jsu_pkg::CH_QUOTE};
        send_span(1'b1);
        set_capacity(16'd3);
        span_bytes = '{jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSL, jsu_pkg::CH_U,
                       8'h30, 8'h30, 8'h45, 8'h39, jsu_pkg::CH_QUOTE};
        send_span(1'b1);
        set_capacity(16'd256);
        span_bytes = '{jsu_pkg::CH_QUOTE, 8'h61, 8'h62};
        send_span(1'b0);
        set_capacity(16'd2);
        send_byte(jsu_pkg::CH_QUOTE, 1'b0, 1'b1);
    endtask

    task automatic test_random_spans(input int idle, input int stall, input logic [15:0] cap,
                                     input int items);
        logic mark_last;
        int   first;
        set_capacity(cap);
        idle_pct  = idle;
        stall_pct = stall;
        first = bytes_sent;
        while (bytes_sent - first < items) begin
            make_span(mark_last);
            send_span(mark_last);
            if ($urandom_range(9) == 0) send_byte(8'($urandom), 1'b0, 1'($urandom_range(1)));
        end
    endtask

    task automatic test_backpressure();
        set_capacity(16'd256);
        idle_pct  = 0;
        stall_pct = 0;
        holdoff_req <= 1'b1;
        @(posedge i_clk);
        holdoff_req <= 1'b0;
        span_bytes = '{jsu_pkg::CH_QUOTE};
        repeat (28) span_bytes.push_back(8'h41 + 8'($urandom_range(25)));
        span_bytes.push_back(jsu_pkg::CH_QUOTE);
        send_span(1'b1);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_capacity_limits();
        test_random_spans(0, 0, 16'd256, 85);
        test_random_spans(45, 0, 16'd65535, 85);
        test_random_spans(0, 45, 16'd6, 85);
        test_random_spans(26, 26, 16'd20, 85);
        test_backpressure();
        wait_drained(FINAL_CYCLES);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
